// ===== rtl/core/lmsm_pkg.sv =====
// Shared types, codes and helpers for the link master state machine.
package lmsm_pkg;

    // Link state, one-hot encoded.
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_PROBE = 4'b0010,
        ST_GRANT = 4'b0100,
        ST_EST   = 4'b1000
    } link_state_t;

    // Binary state codes as they appear on the result stream.
    localparam logic [1:0] CODE_IDLE  = 2'd0;
    localparam logic [1:0] CODE_PROBE = 2'd1;
    localparam logic [1:0] CODE_GRANT = 2'd2;
    localparam logic [1:0] CODE_EST   = 2'd3;

    // Request kinds carried in the input tuser.
    typedef enum logic [1:0] {
        KIND_FRAME = 2'd0,
        KIND_START = 2'd1,
        KIND_GDLV  = 2'd2,
        KIND_LOST  = 2'd3
    } req_kind_t;

    // Received frame types; the two remaining codes are unknown frames.
    localparam logic [2:0] FT_FILLER = 3'd0;
    localparam logic [2:0] FT_JOIN   = 3'd1;
    localparam logic [2:0] FT_CONFIG = 3'd2;
    localparam logic [2:0] FT_UNI    = 3'd3;
    localparam logic [2:0] FT_HBEAT  = 3'd4;
    localparam logic [2:0] FT_BYE    = 3'd5;

    // Protocol events after frame sorting.
    typedef enum logic [3:0] {
        EV_KICK  = 4'd0,
        EV_PRES  = 4'd1,
        EV_JNEW  = 4'd2,
        EV_JSAME = 4'd3,
        EV_CFG   = 4'd4,
        EV_CFGE  = 4'd5,
        EV_ACC   = 4'd6,
        EV_ACCE  = 4'd7,
        EV_BYE   = 4'd8,
        EV_GDLV  = 4'd9,
        EV_LOST  = 4'd10
    } link_event_t;

    // Drop reasons.
    typedef enum logic [1:0] {
        DR_NONE = 2'd0,
        DR_BYE  = 2'd1,
        DR_MAC  = 2'd2,
        DR_GONE = 2'd3
    } drop_reason_t;

    // Outcome of one edge of the link state machine.
    typedef struct packed {
        link_state_t  next_state;
        logic         entry_action;
        drop_reason_t drop_reason;
        logic         report;
    } edge_result_t;

    // Map a one-hot state to its binary code.
    function automatic logic [1:0] state_code(input link_state_t s);
        logic [1:0] code;
        begin
            unique case (s)
                ST_IDLE:  code = CODE_IDLE;
                ST_PROBE: code = CODE_PROBE;
                ST_GRANT: code = CODE_GRANT;
                ST_EST:   code = CODE_EST;
                default:  code = CODE_IDLE;
            endcase
            return code;
        end
    endfunction

endpackage

// ===== rtl/core/link_master_state_machine.sv =====
// Top level of the link master state machine: input register, sort, edge, result register.
// A request held in the input register is processed at the next edge that finds the result
// register free or being drained, and its result is then offered from the result register.
// Throughput: one request per cycle while m_tready is high; input and result registers are
// refilled in the same cycle, and the link state register is the only loop.
// Reset: rst_n clears both valid flags and puts the link state in idle.
module link_master_state_machine (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,  // rx_type[2:0], has_block[3], same_box_flag[4],
                                 // grant_done[5], zero[7:6]
    input  logic [1:0] s_tuser,  // kind[1:0]
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata   // state_out[1:0], entry_action[2], drop_reason[4:3],
                                 // transition_report[5], zero[7:6]
);

    logic                   in_valid_reg;
    logic                   in_valid_next;
    logic [1:0]             in_kind_reg;
    logic [5:0]             in_data_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [5:0]             out_data_reg;
    logic                   in_take;
    logic                   advance;
    lmsm_pkg::link_event_t  ev;
    lmsm_pkg::edge_result_t res;
    lmsm_pkg::link_state_t  cur_state;

    // Handshake: a request moves on when the result register is free or being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    // Input register.
    assign in_valid_next = in_take || (in_valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_kind_reg <= s_tuser;
            in_data_reg <= s_tdata[5:0];
        end
    end

    // Frame sorting.
    lmsm_classify u_classify (
        .kind          (lmsm_pkg::req_kind_t'(in_kind_reg)),
        .rx_type       (in_data_reg[2:0]),
        .has_block     (in_data_reg[3]),
        .same_box_flag (in_data_reg[4]),
        .grant_done    (in_data_reg[5]),
        .ev            (ev)
    );

    // Edge table and link state.
    lmsm_edge u_edge (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .ev    (ev),
        .res   (res),
        .state (cur_state)
    );

    // Result register.
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= {res.report, res.drop_reason, res.entry_action,
                             lmsm_pkg::state_code(res.next_state)};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg};

    // A reported transition always runs the entry action.
    a_report_entry: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[5] |-> m_tdata[2])
        else $error("transition reported without entry action");

    // A drop always comes with the entry action.
    a_drop_entry: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[4:3] != 2'd0) |-> m_tdata[2])
        else $error("drop reason without entry action");

    // The newest result carries the state now held in the state register.
    a_state_match: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_data_reg[1:0] == lmsm_pkg::state_code(cur_state))
        else $error("result state differs from link state");

    // The input side only stalls while a request is held.
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg)
        else $error("input stalled with no request held");

endmodule

// ===== rtl/core/lmsm_classify.sv =====
// Sorts one incoming request into a protocol event.
module lmsm_classify (
    input  lmsm_pkg::req_kind_t   kind,
    input  logic [2:0]            rx_type,
    input  logic                  has_block,
    input  logic                  same_box_flag,
    input  logic                  grant_done,
    output lmsm_pkg::link_event_t ev
);

    lmsm_pkg::link_event_t frame_ev;

    // Frame sorting; unknown frame types count as presence.
    always_comb
    begin
        unique case (rx_type)
            lmsm_pkg::FT_JOIN:
            begin
                if (!has_block)
                    frame_ev = lmsm_pkg::EV_PRES;
                else if (same_box_flag)
                    frame_ev = lmsm_pkg::EV_JSAME;
                else
                    frame_ev = lmsm_pkg::EV_JNEW;
            end
            lmsm_pkg::FT_CONFIG:
                frame_ev = grant_done ? lmsm_pkg::EV_CFG : lmsm_pkg::EV_CFGE;
            lmsm_pkg::FT_UNI, lmsm_pkg::FT_HBEAT:
                frame_ev = grant_done ? lmsm_pkg::EV_ACC : lmsm_pkg::EV_ACCE;
            lmsm_pkg::FT_BYE:
                frame_ev = lmsm_pkg::EV_BYE;
            default:
                frame_ev = lmsm_pkg::EV_PRES;
        endcase
    end

    // Non-frame requests map directly to their event.
    always_comb
    begin
        unique case (kind)
            lmsm_pkg::KIND_FRAME: ev = frame_ev;
            lmsm_pkg::KIND_START: ev = lmsm_pkg::EV_KICK;
            lmsm_pkg::KIND_GDLV:  ev = lmsm_pkg::EV_GDLV;
            lmsm_pkg::KIND_LOST:  ev = lmsm_pkg::EV_LOST;
            default:              ev = lmsm_pkg::EV_LOST;
        endcase
    end

endmodule

// ===== rtl/core/lmsm_edge.sv =====
// Link state register and the edge table that advances it.
module lmsm_edge (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  lmsm_pkg::link_event_t  ev,
    output lmsm_pkg::edge_result_t res,
    output lmsm_pkg::link_state_t  state
);

    lmsm_pkg::link_state_t state_reg;
    lmsm_pkg::link_state_t state_next;

    // Edge table: by default the state holds with no action.
    always_comb
    begin
        res.next_state   = state_reg;
        res.entry_action = 1'b0;
        res.drop_reason  = lmsm_pkg::DR_NONE;
        res.report       = 1'b0;
        unique case (state_reg)
            lmsm_pkg::ST_IDLE:
            begin
                // Start enters probing but is not reported.
                if (ev == lmsm_pkg::EV_KICK)
                begin
                    res.next_state   = lmsm_pkg::ST_PROBE;
                    res.entry_action = 1'b1;
                end
            end
            lmsm_pkg::ST_PROBE:
            begin
                // Any joining box or a config moves on to granting.
                if (ev == lmsm_pkg::EV_JNEW || ev == lmsm_pkg::EV_JSAME ||
                    ev == lmsm_pkg::EV_CFG || ev == lmsm_pkg::EV_CFGE)
                begin
                    res.next_state   = lmsm_pkg::ST_GRANT;
                    res.entry_action = 1'b1;
                    res.report       = 1'b1;
                end
            end
            lmsm_pkg::ST_GRANT:
            begin
                if (ev == lmsm_pkg::EV_JNEW)
                begin
                    // A new box restarts the grant.
                    res.next_state   = lmsm_pkg::ST_GRANT;
                    res.entry_action = 1'b1;
                    res.report       = 1'b1;
                end
                else if (ev == lmsm_pkg::EV_CFG || ev == lmsm_pkg::EV_ACC ||
                         ev == lmsm_pkg::EV_GDLV)
                begin
                    res.next_state   = lmsm_pkg::ST_EST;
                    res.entry_action = 1'b1;
                    res.report       = 1'b1;
                end
                else if (ev == lmsm_pkg::EV_BYE)
                begin
                    res.next_state   = lmsm_pkg::ST_PROBE;
                    res.entry_action = 1'b1;
                    res.drop_reason  = lmsm_pkg::DR_BYE;
                    res.report       = 1'b1;
                end
            end
            lmsm_pkg::ST_EST:
            begin
                if (ev == lmsm_pkg::EV_JNEW)
                begin
                    res.next_state   = lmsm_pkg::ST_GRANT;
                    res.entry_action = 1'b1;
                    res.drop_reason  = lmsm_pkg::DR_MAC;
                    res.report       = 1'b1;
                end
                else if (ev == lmsm_pkg::EV_BYE)
                begin
                    res.next_state   = lmsm_pkg::ST_PROBE;
                    res.entry_action = 1'b1;
                    res.drop_reason  = lmsm_pkg::DR_BYE;
                    res.report       = 1'b1;
                end
                else if (ev == lmsm_pkg::EV_LOST)
                begin
                    res.next_state   = lmsm_pkg::ST_PROBE;
                    res.entry_action = 1'b1;
                    res.drop_reason  = lmsm_pkg::DR_GONE;
                    res.report       = 1'b1;
                end
            end
            default:
                res.next_state = lmsm_pkg::ST_IDLE;
        endcase
    end

    // State advances only when a request is processed.
    assign state_next = step ? res.next_state : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= lmsm_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign state = state_reg;

endmodule

// ===== tb/sv/link_master_state_machine_tb.sv =====
// Self-checking testbench for the link master state machine request and result streams.
module link_master_state_machine_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_REQUESTS = 1850;
    localparam int QUIET_TAIL      = 200;

    // One request as it travels on the input stream.
    typedef struct packed {
        lmsm_pkg::req_kind_t kind;
        logic [2:0]          frame_type;
        logic                has_block;
        logic                latched_box;
        logic                grant_done;
    } link_request_t;

    // One result as it travels on the output stream.
    typedef struct packed {
        logic [1:0]             state_code;
        logic                   entry_action;
        lmsm_pkg::drop_reason_t drop_reason;
        logic                   report;
    } link_result_t;

    // Directed row: the request and, where obvious, its typed-in result.
    typedef struct packed {
        link_request_t req;
        logic          has_typed;
        link_result_t  typed;
    } directed_row_t;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic [1:0] s_tuser;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;

    logic [1:0]   predicted_state;
    link_result_t pending_results[$];
    int           fail_count;
    bit           quiet;

    link_master_state_machine u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Directed requests: every sorting path and every edge of the state machine except the config edge from granting.
    directed_row_t directed_rows [0:25] = '{
        // While idle only a start leaves the state.
        '{'{lmsm_pkg::KIND_FRAME, lmsm_pkg::FT_JOIN, 1'b1, 1'b0, 1'b1}, 1'b1,
          '{lmsm_pkg::CODE_IDLE, 1'b0, lmsm_pkg::DR_NONE, 1'b0}},
        '{'{lmsm_pkg::KIND_LOST, 3'd7, 1'b1, 1'b1, 1'b1}, 1'b1,
          '{lmsm_pkg::CODE_IDLE, 1'b0, lmsm_pkg::DR_NONE, 1'b0}},
        '{'{lmsm_pkg::KIND_GDLV, lmsm_pkg::FT_FILLER, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{lmsm_pkg::CODE_IDLE, 1'b0, lmsm_pkg::DR_NONE, 1'b0}},
        // Start from idle runs the entry action without a report.
        '{'{lmsm_pkg::KIND_START, lmsm_pkg::FT_FILLER, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{lmsm_pkg::CODE_PROBE, 1'b1, lmsm_pkg::DR_NONE, 1'b0}},
        '{'{lmsm_pkg::KIND_LOST, lmsm_pkg::FT_FILLER, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{lmsm_pkg::CODE_PROBE, 1'b0, lmsm_pkg::DR_NONE, 1'b0}},
        '{'{lmsm_pkg::KIND_FRAME, lmsm_pkg::FT_FILLER, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
        '{'{lmsm_pkg::KIND_FRAME, lmsm_pkg::FT_JOIN, 1'b0, 1'b1, 1'b1}, 1'b0, '0},
        '{'{lmsm_pkg::KIND_FRAME, 3'd7, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
        '{'{lmsm_pkg::KIND_FRAME, lmsm_pkg::FT_JOIN, 1'b1, 1'b0, 1'b0}, 1'b1,
          '{lmsm_pkg::CODE_GRANT, 1'b1, lmsm_pkg::DR_NONE, 1'b1}},
        // A join from a new box while granting re-enters granting.
        '{'{lmsm_pkg::KIND_FRAME, lmsm_pkg::FT_JOIN, 1'b1, 1'b0, 1'b1}, 1'b0, '0},
        '{'{lmsm_pkg::KIND_FRAME, lmsm_pkg::FT_JOIN, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
        // Early config and accept, before the grant is delivered, leave granting unchanged.
        '{'{lmsm_pkg::KIND_FRAME, lmsm_pkg::FT_CONFIG, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
        '{'{lmsm_pkg::KIND_FRAME, lmsm_pkg::FT_UNI, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
        '{'{lmsm_pkg::KIND_FRAME, lmsm_pkg::FT_BYE, 1'b1, 1'b1, 1'b1}, 1'b1,
          '{lmsm_pkg::CODE_PROBE, 1'b1, lmsm_pkg::DR_BYE, 1'b1}},
        '{'{lmsm_pkg::KIND_FRAME, lmsm_pkg::FT_CONFIG, 1'b0, 1'b0, 1'b1}, 1'b0, '0},
        '{'{lmsm_pkg::KIND_FRAME, lmsm_pkg::FT_HBEAT, 1'b0, 1'b0, 1'b1}, 1'b0, '0},
        '{'{lmsm_pkg::KIND_FRAME, lmsm_pkg::FT_JOIN, 1'b1, 1'b0, 1'b0}, 1'b1,
          '{lmsm_pkg::CODE_GRANT, 1'b1, lmsm_pkg::DR_MAC, 1'b1}},
        '{'{lmsm_pkg::KIND_GDLV, 3'd7, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
        '{'{lmsm_pkg::KIND_LOST, lmsm_pkg::FT_FILLER, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{lmsm_pkg::CODE_PROBE, 1'b1, lmsm_pkg::DR_GONE, 1'b1}},
        '{'{lmsm_pkg::KIND_FRAME, lmsm_pkg::FT_CONFIG, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
        '{'{lmsm_pkg::KIND_FRAME, lmsm_pkg::FT_UNI, 1'b0, 1'b0, 1'b1}, 1'b0, '0},
        '{'{lmsm_pkg::KIND_FRAME, lmsm_pkg::FT_BYE, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
        '{'{lmsm_pkg::KIND_START, 3'd7, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
        '{'{lmsm_pkg::KIND_FRAME, lmsm_pkg::FT_JOIN, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
        '{'{lmsm_pkg::KIND_LOST, lmsm_pkg::FT_FILLER, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
        '{'{lmsm_pkg::KIND_FRAME, 3'd6, 1'b1, 1'b1, 1'b1}, 1'b0, '0}
    };

    // Sort a request into a protocol event.
    function automatic lmsm_pkg::link_event_t sort_request(input link_request_t r);
        lmsm_pkg::link_event_t ev;
        begin
            case (r.kind)
                lmsm_pkg::KIND_START: ev = lmsm_pkg::EV_KICK;
                lmsm_pkg::KIND_GDLV:  ev = lmsm_pkg::EV_GDLV;
                lmsm_pkg::KIND_LOST:  ev = lmsm_pkg::EV_LOST;
                default:
                begin
                    case (r.frame_type)
                        lmsm_pkg::FT_JOIN:
                            ev = !r.has_block ? lmsm_pkg::EV_PRES
                                 : (r.latched_box ? lmsm_pkg::EV_JSAME
                                                  : lmsm_pkg::EV_JNEW);
                        lmsm_pkg::FT_CONFIG:
                            ev = r.grant_done ? lmsm_pkg::EV_CFG : lmsm_pkg::EV_CFGE;
                        lmsm_pkg::FT_UNI,
                        lmsm_pkg::FT_HBEAT:
                            ev = r.grant_done ? lmsm_pkg::EV_ACC : lmsm_pkg::EV_ACCE;
                        lmsm_pkg::FT_BYE:
                            ev = lmsm_pkg::EV_BYE;
                        default:
                            ev = lmsm_pkg::EV_PRES;
                    endcase
                end
            endcase
            return ev;
        end
    endfunction

    // Work out the edge taken from the given state on the given event.
    function automatic link_result_t next_link_edge(input logic [1:0] cur,
                                                    input lmsm_pkg::link_event_t ev);
        link_result_t res;
        begin
            res = '{cur, 1'b0, lmsm_pkg::DR_NONE, 1'b0};
            case (cur)
                lmsm_pkg::CODE_IDLE:
                    if (ev == lmsm_pkg::EV_KICK)
                        res = '{lmsm_pkg::CODE_PROBE, 1'b1, lmsm_pkg::DR_NONE, 1'b0};
                lmsm_pkg::CODE_PROBE:
                    if (ev inside {lmsm_pkg::EV_JNEW, lmsm_pkg::EV_JSAME,
                                   lmsm_pkg::EV_CFG, lmsm_pkg::EV_CFGE})
                        res = '{lmsm_pkg::CODE_GRANT, 1'b1, lmsm_pkg::DR_NONE, 1'b1};
                lmsm_pkg::CODE_GRANT:
                    if (ev == lmsm_pkg::EV_JNEW)
                        res = '{lmsm_pkg::CODE_GRANT, 1'b1, lmsm_pkg::DR_NONE, 1'b1};
                    else if (ev inside {lmsm_pkg::EV_CFG, lmsm_pkg::EV_ACC,
                                        lmsm_pkg::EV_GDLV})
                        res = '{lmsm_pkg::CODE_EST, 1'b1, lmsm_pkg::DR_NONE, 1'b1};
                    else if (ev == lmsm_pkg::EV_BYE)
                        res = '{lmsm_pkg::CODE_PROBE, 1'b1, lmsm_pkg::DR_BYE, 1'b1};
                default:
                    if (ev == lmsm_pkg::EV_JNEW)
                        res = '{lmsm_pkg::CODE_GRANT, 1'b1, lmsm_pkg::DR_MAC, 1'b1};
                    else if (ev == lmsm_pkg::EV_BYE)
                        res = '{lmsm_pkg::CODE_PROBE, 1'b1, lmsm_pkg::DR_BYE, 1'b1};
                    else if (ev == lmsm_pkg::EV_LOST)
                        res = '{lmsm_pkg::CODE_PROBE, 1'b1, lmsm_pkg::DR_GONE, 1'b1};
            endcase
            return res;
        end
    endfunction

    // Random request, mostly received frames with every field random.
    function automatic link_request_t random_request();
        link_request_t r;
        begin
            case ($urandom_range(0, 9))
                0:       r.kind = lmsm_pkg::KIND_START;
                1:       r.kind = lmsm_pkg::KIND_GDLV;
                2:       r.kind = lmsm_pkg::KIND_LOST;
                default: r.kind = lmsm_pkg::KIND_FRAME;
            endcase
            r.frame_type  = 3'($urandom_range(0, 7));
            r.has_block   = 1'($urandom_range(0, 1));
            r.latched_box = 1'($urandom_range(0, 1));
            r.grant_done  = 1'($urandom_range(0, 1));
            return r;
        end
    endfunction

    // Offer one request, wait for the handshake and queue its expected result.
    task automatic send_request(input link_request_t r, input logic has_typed,
                                input link_result_t typed);
        link_result_t predicted;
        int gap;
        begin
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                gap = $urandom_range(1, 5);
                repeat (gap)
                begin
                    @(negedge clk);
                    s_tvalid = 1'b0;
                end
            end
            @(negedge clk);
            s_tvalid = 1'b1;
            s_tuser  = r.kind;
            s_tdata  = {2'b00, r.grant_done, r.latched_box, r.has_block, r.frame_type};
            do
                @(posedge clk);
            while (!s_tready);
            predicted       = next_link_edge(predicted_state, sort_request(r));
            predicted_state = predicted.state_code;
            pending_results.push_back(has_typed ? typed : predicted);
        end
    endtask

    // Lower the request valid and wait until every expected result is back.
    task automatic drain_results();
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
            while (pending_results.size() != 0)
                @(posedge clk);
        end
    endtask

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Result side back-pressure: random stall bursts, none in the quiet tail.
    initial
    begin
        int n;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (quiet || !rst_n)
                m_tready = 1'b1;
            else if ($urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 5);
                m_tready = 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            else
            begin
                n = $urandom_range(1, 8);
                m_tready = 1'b1;
                repeat (n - 1) @(negedge clk);
            end
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        link_result_t got;
        link_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.state_code   = m_tdata[1:0];
            got.entry_action = m_tdata[2];
            got.drop_reason  = lmsm_pkg::drop_reason_t'(m_tdata[4:3]);
            got.report       = m_tdata[5];
            if (pending_results.size() == 0)
            begin
                $error("unexpected result %0h with no request outstanding", m_tdata);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.state_code !== want.state_code)
                begin
                    $error("state_out: expected %0d, got %0d", want.state_code,
                           got.state_code);
                    fail_count++;
                end
                if (got.entry_action !== want.entry_action)
                begin
                    $error("entry_action: expected %0d, got %0d", want.entry_action,
                           got.entry_action);
                    fail_count++;
                end
                if (got.drop_reason !== want.drop_reason)
                begin
                    $error("drop_reason: expected %0d, got %0d", want.drop_reason,
                           got.drop_reason);
                    fail_count++;
                end
                if (got.report !== want.report)
                begin
                    $error("transition_report: expected %0d, got %0d", want.report,
                           got.report);
                    fail_count++;
                end
            end
        end
    end

    // Main sequence: reset, directed table, pause, random requests, drain.
    initial
    begin
        rst_n           = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = lmsm_pkg::KIND_FRAME;
        quiet           = 1'b0;
        fail_count      = 0;
        predicted_state = lmsm_pkg::CODE_IDLE;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].has_typed,
                         directed_rows[i].typed);

        // Hold the sender off until the block has answered everything.
        drain_results();

        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if (i == RANDOM_REQUESTS - QUIET_TAIL)
                quiet = 1'b1;
            send_request(random_request(), 1'b0, '0);
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("[link_master_state_machine] OK");
        else
            $display("[link_master_state_machine] ERROR");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #5ms;
        $display("[link_master_state_machine] ERROR");
        $finish;
    end

endmodule
